// File: rtl/bsst_pkg.sv
// bsst_pkg: widths, codes and defaults shared by the span tracker files.
// No dependencies; compile first.
`timescale 1ns / 1ps

package bsst_pkg;

  localparam int VALUE_W     = 32;
  localparam int CAP_W       = 7;
  localparam int STATUS_W    = 2;
  localparam int MAX_ENTRIES = 64;

  localparam logic [VALUE_W-1:0] GAP_INIT = '1;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_FEW  = 2'd2
  } status_t;

endpackage

// File: rtl/bsst_if.sv
// bsst_in_if / bsst_out_if: valid/ready channels of the span tracker.
// Depends on bsst_pkg for field widths.
`timescale 1ns / 1ps

interface bsst_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic signed [bsst_pkg::VALUE_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface bsst_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsst_pkg::STATUS_W-1:0] status;
  logic [bsst_pkg::VALUE_W-1:0]  shortest_span;
  logic [bsst_pkg::VALUE_W-1:0]  longest_span;

  modport source (output valid, output status, output shortest_span, output longest_span,
                  input ready);
  modport sink   (input valid, input status, input shortest_span, input longest_span,
                  output ready);
endinterface

// File: rtl/bsst_ram.sv
// bsst_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// File: rtl/bsst_dist.sv
// bsst_dist: registered exact distance between two signed 32-bit values.
// Depends on bsst_pkg for the value width.
`timescale 1ns / 1ps

module bsst_dist (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                vld,
  input  logic signed [bsst_pkg::VALUE_W-1:0] a,
  input  logic signed [bsst_pkg::VALUE_W-1:0] b,
  output logic                                vld_r,
  output logic [bsst_pkg::VALUE_W-1:0]        dist_r
);

  logic [bsst_pkg::VALUE_W:0]   diff;
  logic [bsst_pkg::VALUE_W-1:0] dist_nxt;

  // sign of the widened difference picks the direction of the subtract
  always_comb begin
    diff     = {a[bsst_pkg::VALUE_W-1], a} - {b[bsst_pkg::VALUE_W-1], b};
    dist_nxt = diff[bsst_pkg::VALUE_W] ? (b - a) : diff[bsst_pkg::VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (vld) begin
      dist_r <= dist_nxt;
    end
  end

endmodule

// File: rtl/bounded_set_span_tracker.sv
// bounded_set_span_tracker: bounded multiset of signed values with span queries.
// Depends on bsst_pkg, bsst_if, bsst_ram, bsst_dist.
//
//   channel | dir | handshake        | word
//   in_ch   | in  | valid/ready      | operation, value
//   out_ch  | out | valid/ready      | status, shortest_span, longest_span
//   cfg     | in  | cfg_we, no wait  | capacity
//
// Queries, rejected adds and the first add are answered straight from idle. Any other add scans every
// stored entry through the single RAM read port and distance unit before it answers.
// Synchronous active-low reset empties the set; the RAM needs no clearing.
// One word is in work at a time; the input stalls while out_ch holds an untaken word.
`timescale 1ns / 1ps

module bounded_set_span_tracker #(
  parameter int MAX_ENTRIES = bsst_pkg::MAX_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bsst_in_if.sink                    in_ch,
  bsst_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [bsst_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int VW    = bsst_pkg::VALUE_W;
  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > bsst_pkg::CAP_W) ? CNT_W : bsst_pkg::CAP_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [bsst_pkg::CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0]           count_r;
  logic signed [VW-1:0]       low_r, high_r, value_r;
  logic [VW-1:0]              gap_r;
  logic [AW-1:0]              rd_idx_r, scan_last_r;
  logic                       rd_vld_r;

  logic                       out_vld_r;
  bsst_pkg::status_t          out_status_r;
  logic [VW-1:0]              out_short_r, out_long_r;

  logic                       accept, is_add, full, pop, ram_we, ram_re, scan_done;
  logic [VW-1:0]              rdata_r, dist_r;
  logic                       dist_vld_r;

  assign pop       = out_vld_r && out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_vld_r || out_ch.ready);
  assign accept    = in_ch.valid && in_ch.ready;
  assign is_add    = (in_ch.operation == bsst_pkg::OP_ADD);
  assign full      = (CMP_W'(count_r) >= CMP_W'(capacity_r))
                  || (count_r == CNT_W'(MAX_ENTRIES));
  assign ram_we    = accept && is_add && !full;
  assign ram_re    = (state_r == ST_SCAN);
  assign scan_done = (state_r == ST_DRAIN) && !rd_vld_r && !dist_vld_r;

  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.shortest_span = out_short_r;
  assign out_ch.longest_span  = out_long_r;

  bsst_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (count_r[AW-1:0]),
    .wdata   (in_ch.value),
    .re      (ram_re),
    .raddr   (rd_idx_r),
    .rdata_r (rdata_r)
  );

  bsst_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld    (rd_vld_r),
    .a      (value_r),
    .b      (rdata_r),
    .vld_r  (dist_vld_r),
    .dist_r (dist_r)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ram_we && (count_r != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_r == scan_last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      capacity_r <= '0;
      count_r    <= '0;
      low_r      <= '0;
      high_r     <= '0;
      gap_r      <= bsst_pkg::GAP_INIT;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= ram_re;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      // store the value and fold it into the bounds at once; the scan only reads below it
      if (ram_we) begin
        count_r <= count_r + CNT_W'(1);
        if (count_r == '0) begin
          low_r  <= in_ch.value;
          high_r <= in_ch.value;
        end else begin
          if (in_ch.value < low_r) begin
            low_r <= in_ch.value;
          end
          if (in_ch.value > high_r) begin
            high_r <= in_ch.value;
          end
        end
      end
      if (dist_vld_r && (dist_r < gap_r)) begin
        gap_r <= dist_r;
      end
      if (pop) begin
        out_vld_r <= 1'b0;
      end
      if ((accept && (state_nxt == ST_IDLE)) || scan_done) begin
        out_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r     <= in_ch.value;
      rd_idx_r    <= '0;
      scan_last_r <= AW'(count_r - CNT_W'(1));
    end else if (ram_re) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
  end

  // result word: loaded on an item answered without a scan, or at the end of a scan
  always_ff @(posedge clk) begin
    if (scan_done) begin
      out_status_r <= bsst_pkg::STATUS_OK;
      out_short_r  <= '0;
      out_long_r   <= '0;
    end else if (accept) begin
      out_short_r <= '0;
      out_long_r  <= '0;
      if (is_add) begin
        out_status_r <= full ? bsst_pkg::STATUS_FULL : bsst_pkg::STATUS_OK;
      end else if (count_r < CNT_W'(2)) begin
        out_status_r <= bsst_pkg::STATUS_FEW;
      end else begin
        out_status_r <= bsst_pkg::STATUS_OK;
        out_short_r  <= gap_r;
        out_long_r   <= high_r - low_r;
      end
    end
  end

endmodule
